/* design/cylinder_radial_imperfection_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the cylinder radial imperfection block
// Shared helpers for concurrent checks, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef CYLINDER_RADIAL_IMPERFECTION_MACROS_SVH
`define CYLINDER_RADIAL_IMPERFECTION_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CRI_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define CRI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/cri_pkg.sv */
// ----------------------------------------------------------------------------
// cri_pkg
// Constants, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package cri_pkg;

    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_MODE = 8'd1;

    localparam int unsigned PHASE_W = 32;
    localparam int unsigned ROT_W   = 34;
    localparam logic signed [ROT_W-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [ROT_W-1:0] ONE_Q30  = 34'sd1073741824;

    // atan(2^-i) in phase units, full turn = 2^32
    function automatic logic [PHASE_W-1:0] cri_atan(input logic [4:0] idx);
        logic [PHASE_W-1:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

/* design/cri_if.sv */
// ----------------------------------------------------------------------------
// cri_if
// Valid/ready channels: node input, node result and register write.
// ----------------------------------------------------------------------------
interface cri_in_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic [30:0]                   node_number;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;
    modport source (output valid, node_number, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, node_number, coord_x, coord_y, coord_z, output ready);
endinterface

interface cri_out_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic [30:0]                   out_node_number;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          is_terminator;
    modport source (output valid, out_node_number, out_x, out_y, out_z, is_terminator,
                    input ready);
    modport sink   (input valid, out_node_number, out_x, out_y, out_z, is_terminator,
                    output ready);
endinterface

interface cri_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* design/cylinder_radial_imperfection.sv */
// ----------------------------------------------------------------------------
// cylinder_radial_imperfection
// Radially perturbs mesh nodes: y and z scaled by 1 - amplitude*cos(mode*theta).
// ----------------------------------------------------------------------------
// The block takes one mesh node per cycle while the output side does not stall,
// and returns one result per node, in the order that the nodes came in.
// The angle theta = atan2(z, y) comes from an unrolled vectoring CORDIC of
// CORDIC_STEPS registered steps; cos(wave_mode*theta) from a second unrolled
// rotation CORDIC of the same length; then one stage for the amplitude
// product, one for alpha, and two for the rounded, saturated scaling of y and
// z. The whole pipeline holds when a result waits untaken at the output, so
// throughput is one node per cycle while the sink keeps up. A node number of
// zero is the list terminator: its coordinates come out untouched with
// is_terminator set. Register writes (amplitude at index 0, wave mode at
// index 1, other indexes ignored) are always taken and apply to nodes still
// in flight, so write them only while the pipeline is empty.
module cylinder_radial_imperfection #(
    parameter int COORD_WIDTH  = 32,
    parameter int CORDIC_STEPS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cri_in_if.sink   i_in,
    cri_out_if.source o_out,
    cri_cfg_if.sink  i_cfg
);
    import cri_pkg::*;
    `include "cylinder_radial_imperfection_macros.svh"

    localparam int CW  = COORD_WIDTH;
    localparam int N   = CORDIC_STEPS;
    localparam int VW  = CW + 2;
    localparam int LAT = 2 * N + 6;

    typedef struct packed {
        logic [30:0]          node;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 term;
    } t_side;

    // ---- configuration registers
    logic [15:0] r_amp;
    logic [7:0]  r_mode;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp  <= '0;
            r_mode <= '0;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_AMPLITUDE) r_amp <= i_cfg.data;
            if (i_cfg.index == CFG_WAVE_MODE) r_mode <= i_cfg.data[7:0];
        end
    end

    // ---- pipeline control: advance everything unless the output is stuck
    logic           en;
    logic [LAT-1:0] r_vld;
    t_side          r_side [LAT];
    t_side          n_side;

    assign en = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    assign n_side.node = i_in.node_number;
    assign n_side.x    = i_in.coord_x;
    assign n_side.y    = i_in.coord_y;
    assign n_side.z    = i_in.coord_z;
    assign n_side.term = (i_in.node_number == 31'd0);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side;
            for (int k = 1; k < LAT; k++) r_side[k] <= r_side[k-1];
        end
    end

    // ---- stage 0: fold the left half plane by half a turn
    logic signed [VW-1:0] v_y [N+1];
    logic signed [VW-1:0] v_z [N+1];
    logic [31:0]          v_a [N+1];
    logic signed [VW-1:0] r_y0, r_z0;
    logic [31:0]          r_a0;
    logic signed [VW-1:0] ey, ez;

    assign ey = VW'(i_in.coord_y);
    assign ez = VW'(i_in.coord_z);

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (i_in.coord_y[CW-1]) begin
                r_y0 <= -ey; r_z0 <= -ez; r_a0 <= 32'h8000_0000;
            end else begin
                r_y0 <= ey; r_z0 <= ez; r_a0 <= '0;
            end
        end
    end

    assign v_y[0] = r_y0;
    assign v_z[0] = r_z0;
    assign v_a[0] = r_a0;

    // ---- vectoring CORDIC, one step per stage
    for (genvar g = 0; g < N; g++) begin : g_vec
        cri_vec_stage #(.W(VW), .SHIFT(g)) u_vec (
            .i_clk (i_clk), .i_en (en),
            .i_y (v_y[g]), .i_z (v_z[g]), .i_ang (v_a[g]),
            .o_y (v_y[g+1]), .o_z (v_z[g+1]), .o_ang (v_a[g+1])
        );
    end

    // ---- phase = wave_mode * theta, wrapping
    logic [31:0] r_phase;

    always_ff @(posedge i_clk) begin
        if (en) r_phase <= 32'(40'(r_mode) * 40'(v_a[N]));
    end

    // fold into [-1/4, 1/4) turn; negate the result for the middle quadrants
    logic        fold_neg;
    logic [31:0] fold_p;

    assign fold_neg = (r_phase[31:30] == 2'd1) || (r_phase[31:30] == 2'd2);
    assign fold_p   = fold_neg ? r_phase + 32'h8000_0000 : r_phase;

    logic signed [ROT_W-1:0] c_x [N+1];
    logic signed [ROT_W-1:0] c_y [N+1];
    logic signed [ROT_W-1:0] c_r [N+1];
    logic                    c_n [N+1];

    assign c_x[0] = GAIN_Q30;
    assign c_y[0] = '0;
    assign c_r[0] = ROT_W'(signed'(fold_p));
    assign c_n[0] = fold_neg;

    // ---- rotation CORDIC, one step per stage
    for (genvar g = 0; g < N; g++) begin : g_rot
        cri_rot_stage #(.SHIFT(g)) u_rot (
            .i_clk (i_clk), .i_en (en),
            .i_x (c_x[g]), .i_y (c_y[g]), .i_r (c_r[g]), .i_neg (c_n[g]),
            .o_x (c_x[g+1]), .o_y (c_y[g+1]), .o_r (c_r[g+1]), .o_neg (c_n[g+1])
        );
    end

    // ---- cosine sign and clamp, amplitude product
    logic signed [ROT_W-1:0] cos_s, cos_c;
    logic signed [47:0]      r_prod;
    logic [31:0]             r_alpha;
    logic signed [47:0]      prod_rnd;

    assign cos_s = c_n[N] ? -c_x[N] : c_x[N];
    assign cos_c = (cos_s > ONE_Q30) ? ONE_Q30 : ((cos_s < -ONE_Q30) ? -ONE_Q30 : cos_s);
    assign prod_rnd = (r_prod + 48'sd32768) >>> 16;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod  <= 48'(signed'({1'b0, r_amp})) * 48'(cos_c);
            r_alpha <= 32'(48'(ONE_Q30) - prod_rnd);
        end
    end

    // ---- scaling of y and z, aligned with the side data at stage LAT-3
    logic signed [CW-1:0] s_y, s_z;

    cri_scale #(.CW(CW)) u_scale_y (
        .i_clk (i_clk), .i_en (en), .i_c (r_side[LAT-3].y), .i_alpha (r_alpha), .o_c (s_y)
    );
    cri_scale #(.CW(CW)) u_scale_z (
        .i_clk (i_clk), .i_en (en), .i_c (r_side[LAT-3].z), .i_alpha (r_alpha), .o_c (s_z)
    );

    // ---- output: terminator passes its coordinates untouched
    assign o_out.valid           = r_vld[LAT-1];
    assign o_out.out_node_number = r_side[LAT-1].node;
    assign o_out.out_x           = r_side[LAT-1].x;
    assign o_out.out_y           = r_side[LAT-1].term ? r_side[LAT-1].y : s_y;
    assign o_out.out_z           = r_side[LAT-1].term ? r_side[LAT-1].z : s_z;
    assign o_out.is_terminator   = r_side[LAT-1].term;

    `CRI_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !en, $stable(r_vld))
    `CRI_ASSERT_NEXT(a_advance, i_clk, i_rst_n, en && r_vld[LAT-2], o_out.valid)
    `CRI_ASSERT_SAME(a_term_node, i_clk, i_rst_n, o_out.valid && o_out.is_terminator,
                     o_out.out_node_number == 31'd0)
endmodule

/* design/cri_vec_stage.sv */
// ----------------------------------------------------------------------------
// cri_vec_stage
// One registered step of the vectoring CORDIC that finds the node angle.
// ----------------------------------------------------------------------------
module cri_vec_stage #(
    parameter int W     = 34,
    parameter int SHIFT = 0
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_y,
    input  logic signed [W-1:0] i_z,
    input  logic [31:0]         i_ang,
    output logic signed [W-1:0] o_y,
    output logic signed [W-1:0] o_z,
    output logic [31:0]         o_ang
);
    import cri_pkg::*;

    logic signed [W-1:0] ys, zs;
    logic [31:0]         at;
    logic signed [W-1:0] n_y, n_z;
    logic [31:0]         n_ang;
    logic signed [W-1:0] r_y, r_z;
    logic [31:0]         r_ang;

    assign ys = i_y >>> SHIFT;
    assign zs = i_z >>> SHIFT;
    assign at = cri_atan(5'(SHIFT));

    // rotate toward the positive y axis
    always_comb begin
        if (!i_z[W-1]) begin
            n_y = i_y + zs; n_z = i_z - ys; n_ang = i_ang + at;
        end else begin
            n_y = i_y - zs; n_z = i_z + ys; n_ang = i_ang - at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y <= n_y; r_z <= n_z; r_ang <= n_ang;
        end
    end

    assign o_y = r_y;
    assign o_z = r_z;
    assign o_ang = r_ang;
endmodule

/* design/cri_rot_stage.sv */
// ----------------------------------------------------------------------------
// cri_rot_stage
// One registered step of the rotation CORDIC that forms the cosine.
// ----------------------------------------------------------------------------
module cri_rot_stage #(
    parameter int SHIFT = 0
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [cri_pkg::ROT_W-1:0] i_x,
    input  logic signed [cri_pkg::ROT_W-1:0] i_y,
    input  logic signed [cri_pkg::ROT_W-1:0] i_r,
    input  logic                            i_neg,
    output logic signed [cri_pkg::ROT_W-1:0] o_x,
    output logic signed [cri_pkg::ROT_W-1:0] o_y,
    output logic signed [cri_pkg::ROT_W-1:0] o_r,
    output logic                            o_neg
);
    import cri_pkg::*;

    logic signed [ROT_W-1:0] xs, ys, at;
    logic signed [ROT_W-1:0] n_x, n_y, n_r;
    logic signed [ROT_W-1:0] r_x, r_y, r_r;
    logic                    r_neg;

    assign xs = i_x >>> SHIFT;
    assign ys = i_y >>> SHIFT;
    assign at = signed'({2'b00, cri_atan(5'(SHIFT))});

    always_comb begin
        if (!i_r[ROT_W-1]) begin
            n_x = i_x - ys; n_y = i_y + xs; n_r = i_r - at;
        end else begin
            n_x = i_x + ys; n_y = i_y - xs; n_r = i_r + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x; r_y <= n_y; r_r <= n_r; r_neg <= i_neg;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_r = r_r;
    assign o_neg = r_neg;
endmodule

/* design/cri_scale.sv */
// ----------------------------------------------------------------------------
// cri_scale
// Two-stage scaling of one coordinate by alpha, with rounding and saturation.
// ----------------------------------------------------------------------------
module cri_scale #(
    parameter int CW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_c,
    input  logic [31:0]          i_alpha,
    output logic signed [CW-1:0] o_c
);
    localparam int P1W = CW + 16;
    localparam int P2W = CW + 17;
    localparam int MW  = CW + 3;
    localparam logic [MW-1:0] MAX_POS = (MW'(1) << (CW - 1)) - MW'(1);

    logic [CW-1:0]  mag_in;
    logic [P1W-1:0] n_p1, r_p1;
    logic [P2W-1:0] n_p2, r_p2;
    logic           r_neg;
    logic [P2W-1:0] sum;
    logic [MW-1:0]  mag;
    logic signed [CW-1:0] n_out, r_out;

    assign mag_in = i_c[CW-1] ? CW'(-i_c) : CW'(i_c);
    assign n_p1 = P1W'(mag_in) * P1W'(i_alpha[31:16]);
    assign n_p2 = P2W'(mag_in) * P2W'(i_alpha[15:0]) + P2W'(32'd536870912);

    assign sum = P2W'(r_p1) + (r_p2 >> 16);
    assign mag = MW'(sum >> 14);

    always_comb begin
        if (r_neg) begin
            if (mag > MAX_POS + MW'(1)) n_out = CW'(MAX_POS + MW'(1));
            else n_out = CW'(-mag);
        end else begin
            if (mag > MAX_POS) n_out = CW'(MAX_POS);
            else n_out = CW'(mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1 <= n_p1; r_p2 <= n_p2; r_neg <= i_c[CW-1];
            r_out <= n_out;
        end
    end

    assign o_c = r_out;
endmodule

/* dv/tb_cylinder_radial_imperfection_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cylinder_radial_imperfection_pkg
// Node and result records, plus the predictor of the radial imperfection.
// ----------------------------------------------------------------------------
package tb_cylinder_radial_imperfection_pkg;
    import cri_pkg::*;

    localparam int CW    = 32;
    localparam int STEPS = 16;

    typedef struct packed {
        logic [30:0]          node_number;
        logic signed [CW-1:0] coord_x;
        logic signed [CW-1:0] coord_y;
        logic signed [CW-1:0] coord_z;
    } node_t;

    typedef struct packed {
        logic [30:0]          node_number;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 term;
    } perturbed_t;

    // atan(2^-i) in phase units, full turn = 2^32
    function automatic logic [31:0] atan_phase(input int i);
        logic [31:0] tab [0:31];
        tab = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
                32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
                32'd2670163, 32'd1335087, 32'd667544, 32'd333772, 32'd166886,
                32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215,
                32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81,
                32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};
        return tab[i & 31];
    endfunction

    function automatic logic [31:0] polar_angle(input longint y, input longint z);
        logic [31:0] ang;
        longint      ys;
        longint      zs;
        ang = 32'h0;
        if (y < 0) begin
            y = -y;
            z = -z;
            ang = 32'h8000_0000;
        end
        for (int i = 0; i < STEPS; i++) begin
            ys = y >>> (i & 31);
            zs = z >>> (i & 31);
            if (z >= 0) begin
                y += zs; z -= ys; ang += atan_phase(i);
            end else begin
                y -= zs; z += ys; ang -= atan_phase(i);
            end
        end
        return ang;
    endfunction

    function automatic longint wave_cos(input logic [31:0] p);
        logic   neg;
        longint r;
        longint cx;
        longint cy;
        longint xs;
        longint ys;
        neg = (p[31:30] == 2'd1) || (p[31:30] == 2'd2);
        if (neg) p = p + 32'h8000_0000;
        r  = longint'($signed(p));
        cx = 652032874;
        cy = 0;
        for (int i = 0; i < STEPS; i++) begin
            xs = cx >>> (i & 31);
            ys = cy >>> (i & 31);
            if (r >= 0) begin
                cx -= ys; cy += xs; r -= longint'(atan_phase(i));
            end else begin
                cx += ys; cy -= xs; r += longint'(atan_phase(i));
            end
        end
        if (neg) cx = -cx;
        if (cx > 64'sd1073741824) cx = 64'sd1073741824;
        if (cx < -64'sd1073741824) cx = -64'sd1073741824;
        return cx;
    endfunction

    function automatic logic [CW-1:0] scale_coord(input longint c, input longint alpha);
        logic        neg;
        logic [63:0] m;
        logic [63:0] mag;
        neg = c < 0;
        m   = neg ? -c : c;
        mag = (m * (alpha >> 16) + ((m * (alpha & 64'hFFFF) + (64'd1 << 29)) >> 16)) >> 14;
        if (neg) begin
            if (mag > 64'h8000_0000) mag = 64'h8000_0000;
            return CW'(-mag);
        end
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        return CW'(mag);
    endfunction

    function automatic perturbed_t perturb_node(input node_t n, input logic [15:0] amp,
                                                input logic [7:0] mode);
        perturbed_t  r;
        logic [31:0] ph;
        longint      alpha;
        r.node_number = n.node_number;
        r.x = n.coord_x;
        if (n.node_number == 0) begin
            r.y = n.coord_y;
            r.z = n.coord_z;
            r.term = 1'b1;
            return r;
        end
        ph    = 32'(mode * polar_angle(n.coord_y, n.coord_z));
        alpha = 64'sd1073741824 - ((longint'(amp) * wave_cos(ph) + 32768) >>> 16);
        r.y    = scale_coord(n.coord_y, alpha);
        r.z    = scale_coord(n.coord_z, alpha);
        r.term = 1'b0;
        return r;
    endfunction
endpackage

/* dv/tb_cylinder_radial_imperfection.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cylinder_radial_imperfection
// Streams mesh nodes through several amplitude and wave-mode settings and
// checks every perturbed node against a built-in predictor, in order.
// ----------------------------------------------------------------------------
module tb_cylinder_radial_imperfection;
    import cri_pkg::*;
    import tb_cylinder_radial_imperfection_pkg::*;

    localparam int LATENCY = 2 * STEPS + 6;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cri_in_if  #(.COORD_WIDTH(CW)) in_ch ();
    cri_out_if #(.COORD_WIDTH(CW)) out_ch ();
    cri_cfg_if                     cfg_ch ();

    cylinder_radial_imperfection #(.COORD_WIDTH(CW), .CORDIC_STEPS(STEPS)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    always #4 i_clk = ~i_clk;

    node_t       pending_nodes[$];
    perturbed_t  expected_nodes[$];
    logic [15:0] amplitude = '0;
    logic [7:0]  wave_mode = '0;
    int          error_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_cycles = 0;
    logic        sink_stall_on = 1'b1;
    logic        driver_hold = 1'b0;

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.node_number = '0;
        in_ch.coord_x = '0;
        in_ch.coord_y = '0;
        in_ch.coord_z = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
    end

    // Driver: advance through pending nodes in bursts with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                // predict at acceptance, settings are frozen while nodes are in flight
                expected_nodes.push_back(perturb_node(
                    {in_ch.node_number, in_ch.coord_x, in_ch.coord_y, in_ch.coord_z},
                    amplitude, wave_mode));
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) gap_left <= gap_left - 1;
                if (pending_nodes.size() > 0 && gap_left == 0 && !driver_hold) begin
                    node_t n;
                    n = pending_nodes.pop_front();
                    in_ch.valid       <= 1'b1;
                    in_ch.node_number <= n.node_number;
                    in_ch.coord_x     <= n.coord_x;
                    in_ch.coord_y     <= n.coord_y;
                    in_ch.coord_z     <= n.coord_z;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Sink stall pattern: long hold-off when requested, else on/off phases.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles  <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end else if (sink_stall_on) begin
            out_ch.ready <= ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) == 0) sink_stall_on <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 39) == 0) sink_stall_on <= 1'b1;
        end
    end

    // Monitor: compare each transfer with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_nodes.size() == 0) begin
                $error("unexpected result, node %0d", out_ch.out_node_number);
                error_count++;
            end else begin
                perturbed_t e;
                e = expected_nodes.pop_front();
                if (out_ch.out_node_number !== e.node_number) begin
                    $error("out_node_number: expected %0d, got %0d",
                           e.node_number, out_ch.out_node_number);
                    error_count++;
                end
                if (out_ch.out_x !== e.x) begin
                    $error("out_x: expected %0d, got %0d", e.x, out_ch.out_x);
                    error_count++;
                end
                if (out_ch.out_y !== e.y) begin
                    $error("out_y: expected %0d, got %0d", e.y, out_ch.out_y);
                    error_count++;
                end
                if (out_ch.out_z !== e.z) begin
                    $error("out_z: expected %0d, got %0d", e.z, out_ch.out_z);
                    error_count++;
                end
                if (out_ch.is_terminator !== e.term) begin
                    $error("is_terminator: expected %0b, got %0b",
                           e.term, out_ch.is_terminator);
                    error_count++;
                end
            end
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == CFG_AMPLITUDE) amplitude = value;
        else if (idx == CFG_WAVE_MODE) wave_mode = value[7:0];
        cfg_ch.valid <= 1'b0;
    endtask

    // Hold until every queued and predicted node is through the pipeline.
    task automatic drain();
        while (pending_nodes.size() > 0 || in_ch.valid || expected_nodes.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000);
        endcase
    endfunction

    task automatic queue_node(input logic [30:0] num, input logic [31:0] x,
                              input logic [31:0] y, input logic [31:0] z);
        pending_nodes.push_back({num, x, y, z});
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            queue_node(($urandom_range(0, 40) == 0) ? 31'd0 : 31'($urandom),
                       $urandom, rand_coord(), rand_coord());
    endtask

    initial begin
        logic [15:0] amps [4];
        logic [7:0]  modes [4];
        amps  = '{16'd0, 16'hFFFF, 16'd655, 16'd0};
        modes = '{8'd0, 8'd255, 8'd4, 8'd1};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: amplitude zero leaves the coordinates unchanged.
        queue_node(31'd1, 32'h0001_0000, 32'h0001_0000, 32'h0);
        queue_node(31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        drain();

        write_reg(CFG_AMPLITUDE, 16'hFFFF);
        write_reg(CFG_WAVE_MODE, 8'd2);
        write_reg(8'd7, 16'h1234);              // unused index, ignored
        // Terminator, origin on the axis, extremes and each quadrant.
        queue_node(31'd0, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_node(31'd5, 32'h0, 32'h0, 32'h0);
        queue_node(31'd6, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_node(31'd7, 32'h0, 32'h8000_0000, 32'h8000_0000);
        queue_node(31'd8, 32'h0, 32'h7FFF_FFFF, 32'h0);
        queue_node(31'd9, 32'h0, 32'h0, 32'h7FFF_FFFF);
        queue_node(31'd10, 32'h0, 32'h8000_0000, 32'h0);
        queue_node(31'd11, 32'h0, 32'h0, 32'h8000_0000);
        queue_node(31'd12, 32'h0, 32'h0001_0000, 32'hFFFF_0000);
        queue_node(31'd13, 32'h0, 32'hFFFF_0000, 32'h0001_0000);
        queue_node(31'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_node(31'h2AAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        drain();

        // Long sink hold-off: the pipeline fills up and stalls its input.
        hold_cycles <= 200;
        queue_random(150);
        drain();

        for (int k = 0; k < 4; k++) begin
            write_reg(CFG_AMPLITUDE, amps[k]);
            write_reg(CFG_WAVE_MODE, {8'd0, modes[k]});
            queue_random(70);
            drain();
        end
        for (int k = 0; k < 4; k++) begin
            write_reg(CFG_AMPLITUDE, 16'($urandom));
            write_reg(CFG_WAVE_MODE, 16'($urandom_range(0, 255)));
            queue_random(60);
            // sender pause until the pipeline has emptied, then resume
            wait (pending_nodes.size() < 30);
            driver_hold = 1'b1;
            while (expected_nodes.size() > 0 || in_ch.valid) @(posedge i_clk);
            driver_hold = 1'b0;
            drain();
        end

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("Some tests failed");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+design
design/cri_pkg.sv
design/cri_if.sv
design/cri_vec_stage.sv
design/cri_rot_stage.sv
design/cri_scale.sv
design/cylinder_radial_imperfection.sv
dv/tb_cylinder_radial_imperfection_pkg.sv
dv/tb_cylinder_radial_imperfection.sv
